>>> hw/rtl/tmsd_pkg.sv
// shared constants, window record and queue status types for the trimmed mean decimator
package tmsd_pkg;

    localparam int SAMPLES_PER_WINDOW = 8;
    localparam int WINDOWS_PER_PACKET = 4;

    localparam int NCH      = 3;
    localparam int CH_TEMP  = 0;
    localparam int CH_HUM   = 1;
    localparam int CH_LIGHT = 2;

    localparam int TEMP_W  = 15;
    localparam int HUM_W   = 14;
    localparam int LIGHT_W = 23;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 6;

    // common signed width that holds every channel value
    localparam int VAL_W = LIGHT_W + 1;
    localparam int POS_W = $clog2(SAMPLES_PER_WINDOW);
    localparam int WIN_W = (WINDOWS_PER_PACKET > 1) ? $clog2(WINDOWS_PER_PACKET) : 1;
    localparam int SUM_W = VAL_W + POS_W;

    localparam int DIVISOR = SAMPLES_PER_WINDOW - 2;
    localparam int HALF    = DIVISOR / 2;

    // exact quotient as (x * RECIP) >> RECIP_SHIFT for any x below 2**SUM_W
    localparam int RECIP_SHIFT = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W     = SUM_W + 2;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [NCH-1:0][SUM_W-1:0] sum;
        logic [NCH-1:0][VAL_W-1:0] min_v;
        logic [NCH-1:0][VAL_W-1:0] max_v;
        logic [STAMP_W-1:0]        stamp;
        logic [SLOT_W-1:0]         slot;
        logic                      last;
    } t_window;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

>>> hw/rtl/tmsd_if.sv
// sample and result channel interfaces
interface tmsd_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [tmsd_pkg::TEMP_W-1:0] temp_sample;
    logic [tmsd_pkg::HUM_W-1:0]         humidity_sample;
    logic [tmsd_pkg::LIGHT_W-1:0]       light_sample;
    logic                               climate_ok;
    logic                               light_ok;
    logic [tmsd_pkg::STAMP_W-1:0]       stamp_in;

    modport source (
        output valid, temp_sample, humidity_sample, light_sample, climate_ok, light_ok,
               stamp_in,
        input  ready
    );
    modport sink (
        input  valid, temp_sample, humidity_sample, light_sample, climate_ok, light_ok,
               stamp_in,
        output ready
    );
endinterface

interface tmsd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [tmsd_pkg::TEMP_W-1:0] temp_mean;
    logic [tmsd_pkg::HUM_W-1:0]         humidity_mean;
    logic [tmsd_pkg::LIGHT_W-1:0]       light_mean;
    logic [tmsd_pkg::STAMP_W-1:0]       window_stamp;
    logic [tmsd_pkg::SLOT_W-1:0]        slot_in_packet;
    logic                               packet_last;

    modport source (
        output valid, temp_mean, humidity_mean, light_mean, window_stamp, slot_in_packet,
               packet_last,
        input  ready
    );
    modport sink (
        input  valid, temp_mean, humidity_mean, light_mean, window_stamp, slot_in_packet,
               packet_last,
        output ready
    );
endinterface

>>> hw/rtl/tmsd_front.sv
// front end: slot storage and running sum, minimum and maximum per channel
module tmsd_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    tmsd_in_if.sink                 i_smp,
    input  tmsd_pkg::t_queue_status i_q_stat,
    output logic                    o_push,
    output tmsd_pkg::t_window       o_win
);

    logic [tmsd_pkg::TEMP_W-1:0]  r_temp_slot  [tmsd_pkg::SAMPLES_PER_WINDOW];
    logic [tmsd_pkg::HUM_W-1:0]   r_hum_slot   [tmsd_pkg::SAMPLES_PER_WINDOW];
    logic [tmsd_pkg::LIGHT_W-1:0] r_light_slot [tmsd_pkg::SAMPLES_PER_WINDOW];

    logic [tmsd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [tmsd_pkg::WIN_W-1:0] r_win, n_win;

    logic [tmsd_pkg::SUM_W-1:0] r_sum [tmsd_pkg::NCH];
    logic [tmsd_pkg::SUM_W-1:0] n_sum [tmsd_pkg::NCH];
    logic [tmsd_pkg::VAL_W-1:0] r_min [tmsd_pkg::NCH];
    logic [tmsd_pkg::VAL_W-1:0] n_min [tmsd_pkg::NCH];
    logic [tmsd_pkg::VAL_W-1:0] r_max [tmsd_pkg::NCH];
    logic [tmsd_pkg::VAL_W-1:0] n_max [tmsd_pkg::NCH];
    logic [tmsd_pkg::VAL_W-1:0] cur   [tmsd_pkg::NCH];

    logic [tmsd_pkg::TEMP_W-1:0]  temp_v;
    logic [tmsd_pkg::HUM_W-1:0]   hum_v;
    logic [tmsd_pkg::LIGHT_W-1:0] light_v;

    logic first, last, accept, win_last;

    assign first    = (r_pos == '0);
    assign last     = (r_pos == tmsd_pkg::POS_W'(tmsd_pkg::SAMPLES_PER_WINDOW - 1));
    assign win_last = (r_win == tmsd_pkg::WIN_W'(tmsd_pkg::WINDOWS_PER_PACKET - 1));

    assign i_smp.ready = !last || !i_q_stat.full;
    assign accept      = i_smp.valid && i_smp.ready;
    assign o_push      = accept && last;

    // value that sits in the slot after this sample
    assign temp_v  = i_smp.climate_ok ? i_smp.temp_sample     : r_temp_slot[r_pos];
    assign hum_v   = i_smp.climate_ok ? i_smp.humidity_sample : r_hum_slot[r_pos];
    assign light_v = i_smp.light_ok   ? i_smp.light_sample    : r_light_slot[r_pos];

    assign cur[tmsd_pkg::CH_TEMP] =
        {{(tmsd_pkg::VAL_W - tmsd_pkg::TEMP_W){temp_v[tmsd_pkg::TEMP_W-1]}}, temp_v};
    assign cur[tmsd_pkg::CH_HUM]   = {{(tmsd_pkg::VAL_W - tmsd_pkg::HUM_W){1'b0}}, hum_v};
    assign cur[tmsd_pkg::CH_LIGHT] = {{(tmsd_pkg::VAL_W - tmsd_pkg::LIGHT_W){1'b0}}, light_v};

    always_comb begin
        for (int c = 0; c < tmsd_pkg::NCH; c++) begin
            if (first) begin
                n_sum[c] = tmsd_pkg::SUM_W'(signed'(cur[c]));
                n_min[c] = cur[c];
                n_max[c] = cur[c];
            end else begin
                n_sum[c] = r_sum[c] + tmsd_pkg::SUM_W'(signed'(cur[c]));
                n_min[c] = (signed'(cur[c]) < signed'(r_min[c])) ? cur[c] : r_min[c];
                n_max[c] = (signed'(cur[c]) > signed'(r_max[c])) ? cur[c] : r_max[c];
            end
        end
    end

    always_comb begin
        n_pos = last ? '0 : r_pos + 1'b1;
        n_win = win_last ? '0 : r_win + 1'b1;
    end

    always_comb begin
        for (int c = 0; c < tmsd_pkg::NCH; c++) begin
            o_win.sum[c]   = n_sum[c];
            o_win.min_v[c] = n_min[c];
            o_win.max_v[c] = n_max[c];
        end
        o_win.stamp = i_smp.stamp_in;
        o_win.slot  = tmsd_pkg::SLOT_W'(r_win);
        o_win.last  = win_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_win <= '0;
            for (int i = 0; i < tmsd_pkg::SAMPLES_PER_WINDOW; i++) begin
                r_temp_slot[i]  <= '0;
                r_hum_slot[i]   <= '0;
                r_light_slot[i] <= '0;
            end
            for (int c = 0; c < tmsd_pkg::NCH; c++) begin
                r_sum[c] <= '0;
                r_min[c] <= '0;
                r_max[c] <= '0;
            end
        end else if (accept) begin
            r_pos <= n_pos;
            if (last) begin
                r_win <= n_win;
            end
            r_temp_slot[r_pos]  <= temp_v;
            r_hum_slot[r_pos]   <= hum_v;
            r_light_slot[r_pos] <= light_v;
            for (int c = 0; c < tmsd_pkg::NCH; c++) begin
                r_sum[c] <= n_sum[c];
                r_min[c] <= n_min[c];
                r_max[c] <= n_max[c];
            end
        end
    end

endmodule

>>> hw/rtl/tmsd_queue.sv
// two-entry queue of finished window records between front and back
module tmsd_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  tmsd_pkg::t_window       i_win,
    input  logic                    i_pop,
    output tmsd_pkg::t_window       o_win,
    output tmsd_pkg::t_queue_status o_stat
);

    tmsd_pkg::t_window           r_mem [tmsd_pkg::QDEPTH];
    logic [tmsd_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [tmsd_pkg::QCNT_W-1:0] r_cnt;
    logic                        do_push, do_pop;

    assign o_stat.full  = (r_cnt == tmsd_pkg::QCNT_W'(tmsd_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_win        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hw/rtl/tmsd_back.sv
// back end: trim, round and divide by reciprocal multiply, output register
module tmsd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tmsd_pkg::t_window       i_win,
    input  tmsd_pkg::t_queue_status i_q_stat,
    output logic                    o_pop,
    tmsd_out_if.source              o_res
);

    logic en;

    // stage 1: rounded magnitude and sign
    logic                       r_v1;
    logic [tmsd_pkg::NCH-1:0]   r_neg1;
    logic [tmsd_pkg::SUM_W-1:0] r_mag1 [tmsd_pkg::NCH];
    logic [tmsd_pkg::STAMP_W-1:0] r_stamp1;
    logic [tmsd_pkg::SLOT_W-1:0]  r_slot1;
    logic                         r_last1;

    // stage 2: product
    logic                        r_v2;
    logic [tmsd_pkg::NCH-1:0]    r_neg2;
    logic [tmsd_pkg::PROD_W-1:0] r_prod2 [tmsd_pkg::NCH];
    logic [tmsd_pkg::STAMP_W-1:0] r_stamp2;
    logic [tmsd_pkg::SLOT_W-1:0]  r_slot2;
    logic                         r_last2;

    // stage 3: output register
    logic                         r_v3;
    logic [tmsd_pkg::TEMP_W-1:0]  r_temp3;
    logic [tmsd_pkg::HUM_W-1:0]   r_hum3;
    logic [tmsd_pkg::LIGHT_W-1:0] r_light3;
    logic [tmsd_pkg::STAMP_W-1:0] r_stamp3;
    logic [tmsd_pkg::SLOT_W-1:0]  r_slot3;
    logic                         r_last3;

    logic [tmsd_pkg::SUM_W-1:0] num   [tmsd_pkg::NCH];
    logic [tmsd_pkg::SUM_W-1:0] n_mag [tmsd_pkg::NCH];
    logic [tmsd_pkg::NCH-1:0]   n_neg;
    logic [tmsd_pkg::SUM_W-1:0] quo   [tmsd_pkg::NCH];
    logic [tmsd_pkg::SUM_W-1:0] res   [tmsd_pkg::NCH];

    assign en    = !r_v3 || o_res.ready;
    assign o_pop = en && !i_q_stat.empty;

    always_comb begin
        for (int c = 0; c < tmsd_pkg::NCH; c++) begin
            num[c] = i_win.sum[c]
                   - tmsd_pkg::SUM_W'(signed'(i_win.min_v[c]))
                   - tmsd_pkg::SUM_W'(signed'(i_win.max_v[c]));
            n_neg[c] = num[c][tmsd_pkg::SUM_W-1];
            n_mag[c] = (n_neg[c] ? (~num[c] + 1'b1) : num[c])
                     + tmsd_pkg::SUM_W'(tmsd_pkg::HALF);
        end
    end

    always_comb begin
        for (int c = 0; c < tmsd_pkg::NCH; c++) begin
            quo[c] = tmsd_pkg::SUM_W'(r_prod2[c][tmsd_pkg::PROD_W-1:tmsd_pkg::RECIP_SHIFT]);
            res[c] = r_neg2[c] ? (~quo[c] + 1'b1) : quo[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg1   <= n_neg;
            r_stamp1 <= i_win.stamp;
            r_slot1  <= i_win.slot;
            r_last1  <= i_win.last;
            for (int c = 0; c < tmsd_pkg::NCH; c++) begin
                r_mag1[c]  <= n_mag[c];
                r_prod2[c] <= tmsd_pkg::PROD_W'(r_mag1[c]) * tmsd_pkg::PROD_W'(tmsd_pkg::RECIP);
            end
            r_neg2   <= r_neg1;
            r_stamp2 <= r_stamp1;
            r_slot2  <= r_slot1;
            r_last2  <= r_last1;
            r_temp3  <= res[tmsd_pkg::CH_TEMP][tmsd_pkg::TEMP_W-1:0];
            r_hum3   <= res[tmsd_pkg::CH_HUM][tmsd_pkg::HUM_W-1:0];
            r_light3 <= res[tmsd_pkg::CH_LIGHT][tmsd_pkg::LIGHT_W-1:0];
            r_stamp3 <= r_stamp2;
            r_slot3  <= r_slot2;
            r_last3  <= r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_res.valid          = r_v3;
    assign o_res.temp_mean      = r_temp3;
    assign o_res.humidity_mean  = r_hum3;
    assign o_res.light_mean     = r_light3;
    assign o_res.window_stamp   = r_stamp3;
    assign o_res.slot_in_packet = r_slot3;
    assign o_res.packet_last    = r_last3;

endmodule

>>> hw/rtl/trimmed_mean_sensor_decimator_unit.sv
// top level of the trimmed mean sensor decimator
// Takes one sample tick per clock cycle. Each tick updates the channel slots and the running
// sum, minimum and maximum registers; on the last tick of a window the totals go into a
// two-entry queue, and a three-stage back end (trim and round, reciprocal multiply, output
// register) raises the window result from the output register. The input stalls
// only on a window's last tick while that queue is full, so with the output taken freely the
// block runs at one tick per cycle. Slots clear at reset; no start-up pass is needed.
module trimmed_mean_sensor_decimator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmsd_in_if.sink     i_smp,
    tmsd_out_if.source  o_res
);

    tmsd_pkg::t_window       front_win;
    tmsd_pkg::t_window       q_win;
    tmsd_pkg::t_queue_status q_stat;
    logic                    push;
    logic                    pop;

    tmsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (i_smp),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_win    (front_win)
    );

    tmsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_win   (front_win),
        .i_pop   (pop),
        .o_win   (q_win),
        .o_stat  (q_stat)
    );

    tmsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (q_win),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_res    (o_res)
    );

    // a finished window is never dropped at a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("window record pushed into full queue");

    // a pushed window is held in the queue on the next cycle
    a_push_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_stat.empty)
        else $error("queue empty after window transfer");

    // the back end never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule
